// File: hdl/udvm_input_bit_reader_core_defines.svh
// Assertion macros shared by the bit reader modules.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef UDVM_INPUT_BIT_READER_CORE_DEFINES_SVH
`define UDVM_INPUT_BIT_READER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UIBR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uibr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UIBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uibr assertion failed");

`endif

// File: hdl/uibr_pkg.sv
// Package for the bit reader: payload structs, function codes, sizes and helpers.
// Used by every module of the block; depends on nothing.
package uibr_pkg;

    localparam int ADDR_W    = 12;
    localparam int MSG_BYTES = 1 << ADDR_W;
    localparam int POS_W     = 13;

    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_GET   = 2'd1;
    localparam logic [1:0] FN_START = 2'd2;

    localparam logic [4:0]  MAX_BITS    = 5'd16;
    localparam logic [15:0] SHORT_VALUE = 16'hFBAD;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] byte_address;
        logic [7:0]  byte_value;
        logic [4:0]  bit_count;
        logic        reverse_result;
        logic        packet_bit;
        logic [12:0] message_end;
    } t_in;

    typedef struct packed {
        logic [15:0] bits_value;
        logic        status;
        logic [12:0] next_address;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  lbits;
        logic [3:0]  lcount;
        logic [1:0]  nbytes;
    } t_ext_res;

    function automatic logic [7:0] flip8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

endpackage

// File: hdl/uibr_store.sv
// Message byte store: one write port and one read port with registered read data.
// Depends on uibr_pkg for the request struct and the store size.
module uibr_store (
    input  logic                i_clk,
    input  uibr_pkg::t_mem_req  i_req,
    output logic [7:0]          o_rdata
);
    import uibr_pkg::*;

    logic [7:0] r_mem [MSG_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/uibr_extract.sv
// Bit extraction: merges kept bits with up to two fetched bytes and takes n bits.
// Depends on uibr_pkg for the result struct.
module uibr_extract (
    input  logic [7:0]          i_lbits,
    input  logic [3:0]          i_lcount,
    input  logic [7:0]          i_byte0,
    input  logic [7:0]          i_byte1,
    input  logic [4:0]          i_count,
    input  logic                i_reverse,
    output uibr_pkg::t_ext_res  o_res
);
    import uibr_pkg::*;

    logic [7:0]  lmask;
    logic [23:0] stream;
    logic [23:0] shifted;
    logic [23:0] taken;
    logic [4:0]  lc5;
    logic [4:0]  rest;
    logic [4:0]  nc5;
    logic [1:0]  nbytes;
    logic [15:0] value;
    logic [15:0] flipped;
    logic [15:0] rvalue;

    always_comb begin
        lc5     = {1'b0, i_lcount};
        lmask   = ~(8'hFF >> i_lcount);
        stream  = {i_lbits & lmask, 16'h0000} | ({i_byte0, i_byte1, 8'h00} >> i_lcount);
        taken   = stream >> (5'd24 - i_count);
        value   = taken[15:0];
        rest    = i_count - lc5;
        if (i_count <= lc5) begin
            nbytes = 2'd0;
            nc5    = lc5 - i_count;
        end else if (rest > 5'd8) begin
            nbytes = 2'd2;
            nc5    = 5'd16 - rest;
        end else begin
            nbytes = 2'd1;
            nc5    = 5'd8 - rest;
        end
        shifted = stream << i_count;
        for (int i = 0; i < 16; i++) begin
            flipped[i] = value[15-i];
        end
        rvalue = flipped >> (5'd16 - i_count);

        o_res.value  = i_reverse ? rvalue : value;
        o_res.lbits  = shifted[23:16] & ~(8'hFF >> nc5[3:0]);
        o_res.lcount = nc5[3:0];
        o_res.nbytes = nbytes;
    end

endmodule

// File: hdl/udvm_input_bit_reader_core.sv
// Get: two store reads (at acceptance and in the fetch state), then assembly into the
// result register. Write, start and unused codes go straight to assembly. One item in
// flight; the next input transfer is taken in the cycle after the result is registered.
// Reset is synchronous: read position, kept bits, last P bit and control are cleared;
// the message store is not cleared.
// Top level of the bit reader; depends on uibr_pkg, uibr_store and uibr_extract.
`include "udvm_input_bit_reader_core_defines.svh"

module udvm_input_bit_reader_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  uibr_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output uibr_pkg::t_out  o_out_data
);
    import uibr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_FIN   = 2'd2;

    logic [1:0]  r_state, n_state;
    t_in         r_item;
    logic [12:0] r_rp, n_rp;
    logic [7:0]  r_lb, n_lb;
    logic [3:0]  r_lc, n_lc;
    logic        r_lastp, n_lastp;
    logic [7:0]  r_b0;
    logic        r_oob0;
    logic        r_oob1;
    logic        r_out_valid;
    t_out        r_out, n_out;

    logic        accept;
    logic        fin_go;
    logic [12:0] rp1;
    t_mem_req    mem_req;
    logic [7:0]  rdata;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [3:0]  lc_eff;
    logic [17:0] diff;
    logic [17:0] avail;
    logic        short_data;
    t_ext_res    ext;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign fin_go     = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign rp1        = r_rp + 13'd1;

    always_comb begin
        mem_req.we    = accept && (i_in_data.func == FN_WRITE);
        mem_req.waddr = i_in_data.byte_address;
        mem_req.wdata = i_in_data.byte_value;
        mem_req.re    = (accept && (i_in_data.func == FN_GET)) || (r_state == S_FETCH);
        mem_req.raddr = (r_state == S_FETCH) ? rp1[ADDR_W-1:0] : r_rp[ADDR_W-1:0];
    end

    uibr_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    always_comb begin
        byte0  = r_oob0 ? 8'h00 : r_b0;
        byte1  = r_oob1 ? 8'h00 : rdata;
        if (r_item.packet_bit) begin
            byte0 = flip8(byte0);
            byte1 = flip8(byte1);
        end
        lc_eff = (r_item.packet_bit != r_lastp) ? 4'd0 : r_lc;
        diff   = {5'b0, r_item.message_end} - {5'b0, r_rp};
        avail  = (diff << 3) + {14'b0, lc_eff};
        short_data = (r_item.bit_count > MAX_BITS)
                   || ($signed(avail) < $signed({13'b0, r_item.bit_count}));
    end

    uibr_extract u_extract (
        .i_lbits   (r_lb),
        .i_lcount  (lc_eff),
        .i_byte0   (byte0),
        .i_byte1   (byte1),
        .i_count   (r_item.bit_count),
        .i_reverse (r_item.reverse_result),
        .o_res     (ext)
    );

    always_comb begin
        n_rp    = r_rp;
        n_lb    = r_lb;
        n_lc    = r_lc;
        n_lastp = r_lastp;
        n_out.bits_value = 16'h0000;
        n_out.status     = 1'b0;
        case (r_item.func)
            FN_GET: begin
                n_lastp = r_item.packet_bit;
                if (short_data) begin
                    n_lc             = lc_eff;
                    n_out.bits_value = SHORT_VALUE;
                    n_out.status     = 1'b1;
                end else begin
                    n_rp             = r_rp + {11'b0, ext.nbytes};
                    n_lb             = ext.lbits;
                    n_lc             = ext.lcount;
                    n_out.bits_value = ext.value;
                end
            end
            FN_START: begin
                n_rp = {1'b0, r_item.byte_address};
                n_lb = 8'h00;
                n_lc = 4'd0;
            end
            default: begin
            end
        endcase
        n_out.next_address = n_rp;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in_data.func == FN_GET) ? S_FETCH : S_FIN;
                end
            end
            S_FETCH: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= 13'd0;
            r_lb        <= 8'h00;
            r_lc        <= 4'd0;
            r_lastp     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go) begin
                r_rp        <= n_rp;
                r_lb        <= n_lb;
                r_lc        <= n_lc;
                r_lastp     <= n_lastp;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_data;
            r_oob0 <= r_rp[POS_W-1];
        end
        if (r_state == S_FETCH) begin
            r_b0   <= rdata;
            r_oob1 <= rp1[POS_W-1];
        end
        if (fin_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `UIBR_ASSERT_NOW(a_lc_range, i_clk, i_rst_n, 1'b1, r_lc <= 4'd8)
    `UIBR_ASSERT_NOW(a_short_value, i_clk, i_rst_n, o_out_valid && o_out_data.status, o_out_data.bits_value == SHORT_VALUE)
    `UIBR_ASSERT_NEXT(a_fin_hold, i_clk, i_rst_n, (r_state == S_FIN) && r_out_valid && i_out_stall, r_state == S_FIN)
    `UIBR_ASSERT_NEXT(a_lastp_upd, i_clk, i_rst_n, fin_go && (r_item.func == FN_GET), r_lastp == $past(r_item.packet_bit))

endmodule

// File: test/udvm_input_bit_reader_core_tb.sv
// Self-checking testbench for udvm_input_bit_reader_core: a directed table and random message
// sequences are checked per transfer against typed row values or a behavioral bit reader.
// Depends on uibr_pkg and the udvm_input_bit_reader_core RTL.
module udvm_input_bit_reader_core_tb;
    import uibr_pkg::*;

    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS    = 850;
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_CYCLES = 150;
    localparam int NUM_ROWS        = 23;

    typedef struct packed {
        t_in  item;
        logic typed;
        t_out want;
    } t_dir_row;

    typedef enum {PH_WRITE, PH_START, PH_GET} t_seq_phase;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    // Predicted state of the reader.
    logic [7:0]  msg_store    [0:MSG_BYTES-1];
    bit          byte_written [0:MSG_BYTES-1];
    logic [12:0] rd_pos;
    logic [7:0]  kept_bits;
    int          kept_count;
    logic        last_p;

    t_out     pending_results [$];
    t_dir_row directed_queue  [$];
    int       error_count = 0;
    bit       stim_done   = 1'b0;

    // Random message sequence state.
    t_seq_phase  seq_phase  = PH_GET;
    int          seq_base   = 0;
    int          seq_len    = 0;
    int          seq_idx    = 0;
    int          gets_left  = 0;
    logic [12:0] seq_end    = '0;
    logic        seq_p      = 1'b0;
    t_in         held_get;
    bit          held_valid = 1'b0;

    //   func       addr       byte   len    rev   P     end        typed value        st    next
    t_dir_row directed_rows [0:NUM_ROWS-1] = '{
        {FN_GET,    12'd0,    8'h00, 5'd0,  1'b0, 1'b0, 13'd0,    1'b1, 16'h0000,   1'b0, 13'd0},
        {FN_GET,    12'd0,    8'h00, 5'd1,  1'b0, 1'b0, 13'd0,    1'b1, SHORT_VALUE, 1'b1, 13'd0},
        {FN_GET,    12'd0,    8'h00, 5'd17, 1'b0, 1'b0, 13'd4096, 1'b1, SHORT_VALUE, 1'b1, 13'd0},
        {FN_GET,    12'd4095, 8'hFF, 5'd31, 1'b1, 1'b1, 13'd8191, 1'b1, SHORT_VALUE, 1'b1, 13'd0},
        {FN_UNUSED, 12'd4095, 8'hFF, 5'd31, 1'b1, 1'b1, 13'd8191, 1'b1, 16'h0000,   1'b0, 13'd0},
        {FN_WRITE,  12'd0,    8'hA5, 5'd0,  1'b0, 1'b0, 13'd0,    1'b1, 16'h0000,   1'b0, 13'd0},
        {FN_WRITE,  12'd1,    8'h3C, 5'd0,  1'b0, 1'b0, 13'd0,    1'b1, 16'h0000,   1'b0, 13'd0},
        {FN_WRITE,  12'd2,    8'hFF, 5'd0,  1'b0, 1'b0, 13'd0,    1'b1, 16'h0000,   1'b0, 13'd0},
        {FN_WRITE,  12'd4095, 8'h81, 5'd31, 1'b1, 1'b1, 13'd8191, 1'b1, 16'h0000,   1'b0, 13'd0},
        {FN_START,  12'd0,    8'h00, 5'd0,  1'b0, 1'b0, 13'd0,    1'b1, 16'h0000,   1'b0, 13'd0},
        {FN_GET,    12'd0,    8'h00, 5'd16, 1'b0, 1'b0, 13'd3,    1'b0, 16'h0000,   1'b0, 13'd0},
        {FN_GET,    12'd0,    8'h00, 5'd3,  1'b0, 1'b0, 13'd3,    1'b0, 16'h0000,   1'b0, 13'd0},
        {FN_GET,    12'd0,    8'h00, 5'd5,  1'b0, 1'b1, 13'd3,    1'b0, 16'h0000,   1'b0, 13'd0},
        {FN_START,  12'd1,    8'h00, 5'd0,  1'b0, 1'b0, 13'd0,    1'b1, 16'h0000,   1'b0, 13'd1},
        {FN_GET,    12'd0,    8'h00, 5'd12, 1'b1, 1'b1, 13'd3,    1'b0, 16'h0000,   1'b0, 13'd0},
        {FN_GET,    12'd0,    8'h00, 5'd4,  1'b0, 1'b1, 13'd3,    1'b0, 16'h0000,   1'b0, 13'd0},
        {FN_START,  12'd4095, 8'h00, 5'd0,  1'b0, 1'b0, 13'd0,    1'b1, 16'h0000,   1'b0, 13'd4095},
        {FN_GET,    12'd0,    8'h00, 5'd16, 1'b1, 1'b0, 13'd4097, 1'b0, 16'h0000,   1'b0, 13'd0},
        {FN_GET,    12'd0,    8'h00, 5'd1,  1'b0, 1'b0, 13'd4096, 1'b0, 16'h0000,   1'b0, 13'd0},
        {FN_START,  12'd0,    8'h00, 5'd0,  1'b0, 1'b0, 13'd0,    1'b1, 16'h0000,   1'b0, 13'd0},
        {FN_GET,    12'd0,    8'h00, 5'd8,  1'b0, 1'b0, 13'd0,    1'b1, SHORT_VALUE, 1'b1, 13'd0},
        {FN_GET,    12'd0,    8'h00, 5'd16, 1'b1, 1'b1, 13'd4096, 1'b0, 16'h0000,   1'b0, 13'd0},
        {FN_WRITE,  12'd4095, 8'h00, 5'd0,  1'b0, 1'b0, 13'd0,    1'b0, 16'h0000,   1'b0, 13'd0}
    };

    udvm_input_bit_reader_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    function automatic logic [7:0] mirror8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] mirror16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[15-i];
        end
        return r;
    endfunction

    task automatic predict_read(input t_in it, output t_out res);
        int avail;
        int need;
        int take;
        int value;
        logic [7:0] fetched;
        value = 0;
        res   = '0;
        case (it.func)
            FN_WRITE: begin
                msg_store[it.byte_address]    = it.byte_value;
                byte_written[it.byte_address] = 1'b1;
            end
            FN_START: begin
                rd_pos     = {1'b0, it.byte_address};
                kept_bits  = '0;
                kept_count = 0;
            end
            FN_GET: begin
                if (it.packet_bit != last_p) begin
                    kept_count = 0;
                    last_p     = it.packet_bit;
                end
                avail = kept_count + (int'(it.message_end) - int'(rd_pos)) * 8;
                if (it.bit_count > MAX_BITS || avail < int'(it.bit_count)) begin
                    res.status = 1'b1;
                    value      = SHORT_VALUE;
                end else begin
                    need = it.bit_count;
                    while (need > 0) begin
                        if (kept_count == 0) begin
                            fetched    = (rd_pos < MSG_BYTES) ? msg_store[rd_pos[11:0]] : 8'h00;
                            kept_bits  = it.packet_bit ? mirror8(fetched) : fetched;
                            kept_count = 8;
                            rd_pos     = rd_pos + 13'd1;
                        end
                        take       = (need < kept_count) ? need : kept_count;
                        value      = (value << take) | (int'(kept_bits) >> (8 - take));
                        kept_bits  = kept_bits << take;
                        kept_count = kept_count - take;
                        need       = need - take;
                    end
                    if (it.reverse_result) begin
                        value = int'(mirror16(value[15:0])) >> (16 - int'(it.bit_count));
                    end
                end
            end
            default: begin
            end
        endcase
        res.bits_value   = value[15:0];
        res.next_address = rd_pos;
    endtask

    // Mostly well-formed sequences (write bytes, start, several gets) with some noise.
    // A get that would read a never-written byte is preceded by a write of that byte.
    task automatic next_random_item(output t_in it);
        t_in cand;
        int lc;
        int avail;
        int nbytes;
        logic [12:0] addr;
        if (held_valid) begin
            cand       = held_get;
            held_valid = 1'b0;
        end else begin
            cand.func           = FN_GET;
            cand.byte_address   = 12'($urandom_range(0, MSG_BYTES - 1));
            cand.byte_value     = 8'($urandom_range(0, 255));
            cand.bit_count      = 5'($urandom_range(0, 16));
            cand.reverse_result = 1'($urandom_range(0, 1));
            cand.packet_bit     = seq_p;
            cand.message_end    = seq_end;
            if ($urandom_range(0, 99) < 12) begin
                cand.func        = 2'($urandom_range(0, 3));
                cand.bit_count   = 5'($urandom_range(0, 31));
                cand.packet_bit  = 1'($urandom_range(0, 1));
                cand.message_end = 13'($urandom_range(0, 8191));
            end else begin
                if (seq_phase == PH_GET && gets_left == 0) begin
                    seq_len  = $urandom_range(1, 12);
                    seq_base = ($urandom_range(0, 9) == 0) ? MSG_BYTES - seq_len
                                                           : $urandom_range(0, MSG_BYTES - seq_len);
                    seq_end  = 13'(seq_base + seq_len);
                    if ($urandom_range(0, 6) == 0) begin
                        seq_end = seq_end + 13'($urandom_range(1, 2));
                    end
                    seq_idx   = 0;
                    seq_phase = PH_WRITE;
                end
                case (seq_phase)
                    PH_WRITE: begin
                        cand.func         = FN_WRITE;
                        cand.byte_address = 12'(seq_base + seq_idx);
                        seq_idx++;
                        if (seq_idx == seq_len) begin
                            seq_phase = PH_START;
                        end
                    end
                    PH_START: begin
                        cand.func         = FN_START;
                        cand.byte_address = 12'(seq_base);
                        seq_phase         = PH_GET;
                        gets_left         = $urandom_range(2, 12);
                    end
                    default: begin
                        if ($urandom_range(0, 9) == 0) begin
                            seq_p = ~seq_p;
                        end
                        cand.packet_bit  = seq_p;
                        cand.message_end = seq_end;
                        if ($urandom_range(0, 19) == 0) begin
                            cand.bit_count = 5'($urandom_range(17, 31));
                        end
                        gets_left--;
                    end
                endcase
            end
        end
        if (cand.func == FN_GET) begin
            lc    = (cand.packet_bit != last_p) ? 0 : kept_count;
            avail = lc + (int'(cand.message_end) - int'(rd_pos)) * 8;
            if (cand.bit_count <= MAX_BITS && avail >= int'(cand.bit_count)
                    && int'(cand.bit_count) > lc) begin
                nbytes = (int'(cand.bit_count) - lc + 7) / 8;
                for (int k = 0; k < nbytes; k++) begin
                    addr = rd_pos + 13'(k);
                    if (!held_valid && addr < MSG_BYTES && !byte_written[addr[11:0]]) begin
                        held_get          = cand;
                        held_valid        = 1'b1;
                        cand.func         = FN_WRITE;
                        cand.byte_address = addr[11:0];
                        cand.byte_value   = 8'($urandom_range(0, 255));
                    end
                end
            end
        end
        it = cand;
    endtask

    always @(posedge clk) begin : drive_inputs
        t_out     predicted;
        t_in      fresh;
        t_dir_row row;
        logic     offer_typed;
        t_out     offer_want;
        int       random_issued;
        int       burst_left;
        int       gap_left;
        bit       loaded;
        if (!rst_n) begin
            in_valid      <= 1'b0;
            rd_pos         = '0;
            kept_bits      = '0;
            kept_count     = 0;
            last_p         = 1'b0;
            random_issued  = 0;
            burst_left     = 4;
            gap_left       = 0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_read(in_data, predicted);
                pending_results.push_back(offer_typed ? offer_want : predicted);
            end
            if (!in_valid || !in_stall) begin
                loaded = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (directed_queue.size() > 0) begin
                    row         = directed_queue.pop_front();
                    in_data    <= row.item;
                    offer_typed = row.typed;
                    offer_want  = row.want;
                    loaded      = 1'b1;
                end else if (random_issued < RANDOM_ITEMS) begin
                    next_random_item(fresh);
                    random_issued++;
                    in_data    <= fresh;
                    offer_typed = 1'b0;
                    loaded      = 1'b1;
                end else begin
                    in_valid <= 1'b0;
                    stim_done = 1'b1;
                end
                if (loaded) begin
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin : check_outputs
        t_out        want;
        int          results_seen;
        int          hold_left;
        bit          pressure_done;
        int          stall_mode;
        logic [31:0] stall_phase;
        if (!rst_n) begin
            out_stall    <= 1'b0;
            results_seen  = 0;
            hold_left     = 0;
            pressure_done = 1'b0;
            stall_mode    = 0;
            stall_phase   = '0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected transfer, expected none, actual %h", $time, out_data);
                end else begin
                    want = pending_results.pop_front();
                    if (out_data.bits_value !== want.bits_value) begin
                        error_count++;
                        $display("%0t: bits_value expected %h actual %h",
                                 $time, want.bits_value, out_data.bits_value);
                    end
                    if (out_data.status !== want.status) begin
                        error_count++;
                        $display("%0t: status expected %b actual %b",
                                 $time, want.status, out_data.status);
                    end
                    if (out_data.next_address !== want.next_address) begin
                        error_count++;
                        $display("%0t: next_address expected %0d actual %0d",
                                 $time, want.next_address, out_data.next_address);
                    end
                end
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (results_seen == PRESSURE_AT && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_CYCLES - 1;
                out_stall    <= 1'b1;
            end else begin
                stall_phase = stall_phase + 1;
                if (stall_phase[6:0] == 7'd0) begin
                    stall_mode = $urandom_range(0, 3);
                end
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= stall_phase[2];
                endcase
            end
        end
    end

    initial begin
        foreach (directed_rows[i]) begin
            directed_queue.push_back(directed_rows[i]);
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (!stim_done || pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
